>>> hw/rtl/sem_pkg.sv
package sem_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int CfgW = 11;
  localparam int PixW = 24;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [1:0] AddrImageWidth = 2'd0;

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseLater  = 2'd2;

  // One classified job handed from the front part to the back part.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            col_zero;
    logic            last;
    logic            flush;
    logic            emitting;
    logic            top_zero;
    logic [PixW-1:0] pix;
  } job_t;

  // Signed gradient of one channel: range -1020..1020.
  typedef logic signed [11:0] grad_t;

endpackage

>>> hw/rtl/sem_ram.sv
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sem_front.sv
module sem_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [sem_pkg::CfgW-1:0] width_reg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     req_type,
  input  logic [7:0]               pixel_red,
  input  logic [7:0]               pixel_green,
  input  logic [7:0]               pixel_blue,
  output logic                     job_valid,
  input  logic                     job_ready,
  output sem_pkg::job_t            job
);

  sem_pkg::job_t              q_mem [sem_pkg::QDepth];
  logic [sem_pkg::QPtrW-1:0]  wptr;
  logic [sem_pkg::QPtrW-1:0]  rptr;
  logic [sem_pkg::QPtrW:0]    count;
  logic [sem_pkg::ColW-1:0]   column_count;
  logic [1:0]                 row_phase;
  logic [sem_pkg::ColW:0]     wact;
  sem_pkg::job_t              new_job;
  logic                       push;
  logic                       pop;

  always_comb begin
    if (width_reg == '0) begin
      wact = (sem_pkg::ColW+1)'(1);
    end else if (width_reg > sem_pkg::CfgW'(sem_pkg::MaxWidth)) begin
      wact = (sem_pkg::ColW+1)'(sem_pkg::MaxWidth);
    end else begin
      wact = width_reg[sem_pkg::ColW:0];
    end
  end

  assign in_ready = (count != (sem_pkg::QPtrW+1)'(sem_pkg::QDepth));
  assign push = in_valid && in_ready;
  assign job_valid = (count != '0);
  assign pop = job_valid && job_ready;
  assign job = q_mem[rptr];

  always_comb begin
    new_job.col      = column_count;
    new_job.col_zero = (column_count == '0);
    new_job.last     = ({1'b0, column_count} >= wact - 1'b1);
    new_job.flush    = req_type;
    new_job.emitting = (row_phase != sem_pkg::PhaseFirst);
    new_job.top_zero = (row_phase == sem_pkg::PhaseSecond);
    new_job.pix      = req_type ? '0 : {pixel_red, pixel_green, pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= new_job;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      column_count <= '0;
      row_phase <= sem_pkg::PhaseFirst;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
        if (new_job.last) begin
          column_count <= '0;
          if (req_type) begin
            row_phase <= sem_pkg::PhaseFirst;
          end else if (row_phase == sem_pkg::PhaseFirst) begin
            row_phase <= sem_pkg::PhaseSecond;
          end else begin
            row_phase <= sem_pkg::PhaseLater;
          end
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (sem_pkg::QPtrW+1)'(push) - (sem_pkg::QPtrW+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/sem_back.sv
module sem_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  sem_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    edge_red,
  output logic [7:0]    edge_green,
  output logic [7:0]    edge_blue,
  output logic          end_of_row,
  output logic          end_of_frame
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WIN, S_SUM, S_ROOT, S_OUT
  } state_t;

  state_t                 state;
  sem_pkg::job_t          cur;
  logic [sem_pkg::PixW-1:0] up_rd;
  logic [sem_pkg::PixW-1:0] lo_rd;
  logic [sem_pkg::PixW-1:0] win [9];
  logic [sem_pkg::PixW-1:0] sel [9];
  logic                   second;
  logic                   pend_second;
  logic [20:0]            sq [3];
  logic [7:0]             q [3];
  logic [3:0]             bitpos;
  logic                   ram_we;
  sem_pkg::grad_t         gx [3];
  sem_pkg::grad_t         gy [3];
  logic                   second_next;

  assign job_ready = (state == S_IDLE);
  assign ram_we = (state == S_WIN);

  sem_ram #(.Width(sem_pkg::PixW), .Depth(sem_pkg::MaxWidth)) u_upper (
    .clk(clk), .we(ram_we), .waddr(cur.col), .wdata(lo_rd),
    .raddr(cur.col), .rdata(up_rd)
  );
  sem_ram #(.Width(sem_pkg::PixW), .Depth(sem_pkg::MaxWidth)) u_lower (
    .clk(clk), .we(ram_we), .waddr(cur.col), .wdata(cur.pix),
    .raddr(cur.col), .rdata(lo_rd)
  );

  // The second result of a row end uses the window shifted left with a zero column.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (second) begin
        sel[r*3]   = win[r*3+1];
        sel[r*3+1] = win[r*3+2];
        sel[r*3+2] = '0;
      end else begin
        sel[r*3]   = win[r*3];
        sel[r*3+1] = win[r*3+1];
        sel[r*3+2] = win[r*3+2];
      end
    end
    for (int k = 0; k < 3; k++) begin
      gx[k] = -$signed({4'd0, sel[0][16-8*k +: 8]}) + $signed({4'd0, sel[2][16-8*k +: 8]})
            - $signed({3'd0, sel[3][16-8*k +: 8], 1'b0})
            + $signed({3'd0, sel[5][16-8*k +: 8], 1'b0})
            - $signed({4'd0, sel[6][16-8*k +: 8]}) + $signed({4'd0, sel[8][16-8*k +: 8]});
      gy[k] = -$signed({4'd0, sel[0][16-8*k +: 8]})
            - $signed({3'd0, sel[1][16-8*k +: 8], 1'b0})
            - $signed({4'd0, sel[2][16-8*k +: 8]}) + $signed({4'd0, sel[6][16-8*k +: 8]})
            + $signed({3'd0, sel[7][16-8*k +: 8], 1'b0})
            + $signed({4'd0, sel[8][16-8*k +: 8]});
    end
  end

  always_comb begin
    second_next = 1'b0;
    if (cur.emitting && cur.last && !second && !cur.col_zero) begin
      second_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WIN;
        end
        S_WIN: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3]   <= cur.col_zero ? '0 : win[r*3+1];
            win[r*3+1] <= cur.col_zero ? '0 : win[r*3+2];
          end
          win[2] <= cur.top_zero ? '0 : up_rd;
          win[5] <= lo_rd;
          win[8] <= cur.pix;
          if (cur.emitting && !cur.col_zero) begin
            second <= 1'b0;
            pend_second <= cur.last;
            state <= S_SUM;
          end else if (cur.emitting && cur.last) begin
            second <= 1'b1;
            pend_second <= 1'b0;
            state <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          for (int k = 0; k < 3; k++) begin
            sq[k] <= 21'(32'(gx[k] * gx[k]) + 32'(gy[k] * gy[k]));
            q[k] <= '0;
          end
          bitpos <= 4'd8;
          state <= S_ROOT;
        end
        S_ROOT: begin
          // One bit of each square root per cycle, high bit first.
          if (bitpos == 4'd0) begin
            edge_red   <= (sq[0] > 21'd65280) ? 8'd255 :
                          (sq[0] > 21'(q[0] * q[0]) + 21'(q[0])) ? q[0] + 1'b1 : q[0];
            edge_green <= (sq[1] > 21'd65280) ? 8'd255 :
                          (sq[1] > 21'(q[1] * q[1]) + 21'(q[1])) ? q[1] + 1'b1 : q[1];
            edge_blue  <= (sq[2] > 21'd65280) ? 8'd255 :
                          (sq[2] > 21'(q[2] * q[2]) + 21'(q[2])) ? q[2] + 1'b1 : q[2];
            end_of_row <= second;
            end_of_frame <= second && cur.flush;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (17'((q[k] | (8'd1 << (bitpos - 1'b1))) * (q[k] | (8'd1 << (bitpos - 1'b1))))
                  <= sq[k]) begin
                q[k] <= q[k] | (8'd1 << (bitpos - 1'b1));
              end
            end
            bitpos <= bitpos - 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (pend_second) begin
              pend_second <= 1'b0;
              second <= second_next;
              state <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude, per RGB channel, over a 3x3 window.
// Up to four accepted items wait in a queue while the back part works on one item at
// a time: it reads the line stores, shifts the window, forms the gradients, takes a
// bit-serial square root per channel, and also gives the row-end result. Reset
// (rst, synchronous, active high) empties the queue, clears the counters and window,
// and sets the width to 1024.
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_red,
  output logic [7:0]  edge_green,
  output logic [7:0]  edge_blue,
  output logic        end_of_row,
  output logic        end_of_frame
);

  logic [sem_pkg::CfgW-1:0] image_width;
  logic                     job_valid;
  logic                     job_ready;
  sem_pkg::job_t            job;

  assign pready = 1'b1;
  assign prdata = (paddr == sem_pkg::AddrImageWidth) ? {21'd0, image_width} : 32'd0;

  // The width register; the front part clamps it into the legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sem_pkg::CfgW'(sem_pkg::MaxWidth);
    end else if (psel && penable && pwrite && paddr == sem_pkg::AddrImageWidth) begin
      image_width <= pwdata[sem_pkg::CfgW-1:0];
    end
  end

  // The front part classifies each item and the queue decouples it from the back part.
  sem_front u_front (
    .clk(clk), .rst(rst), .width_reg(image_width),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  // The back part holds the line stores and window and computes the magnitudes.
  sem_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
    .end_of_row(end_of_row), .end_of_frame(end_of_frame)
  );

endmodule

>>> hw/rtl/sem_checker.sv
module sem_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic end_of_row,
  input logic end_of_frame,
  input logic [7:0] edge_red,
  input logic pready
);

  a_eof_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row) else $error("frame end without row end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(edge_red)) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .end_of_row(end_of_row), .end_of_frame(end_of_frame), .edge_red(edge_red),
  .pready(pready)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

// Testbench for the RGB Sobel edge magnitude block.
//
// Pixels go in through a valid/ready channel. Edge results come back through a second
// valid/ready channel. The image width is set through an APB-style register port.
// A driver process takes items from a queue of pending pixels. An initial block fills
// that queue frame by frame. Each accepted item runs through a local model of the
// line stores and the 3x3 window. The model pushes the edge results that the item
// causes onto a queue. A monitor process compares each result that arrives with the
// oldest entry on that queue, field by field.
module tb;

  localparam int HoldCycles = 400;
  localparam int DrainCycles = 60;
  localparam int QuietLimit = 5000;

  typedef enum logic {ReqPixel = 1'b0, ReqFlush = 1'b1} req_t;

  typedef struct {
    req_t        kind;
    logic [23:0] rgb;
  } pixel_item_t;

  typedef struct {
    logic [7:0] mag [3];
    logic       eor;
    logic       eof;
  } edge_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0, in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  pixel_red = '0, pixel_green = '0, pixel_blue = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [7:0]  edge_red, edge_green, edge_blue;
  logic        end_of_row, end_of_frame;

  sobel_edge_magnitude_rgb dut (.*);

  always #5 clk = ~clk;

  // Stimulus and the expected edge results.
  pixel_item_t  pending_pixels [$];
  edge_result_t expected_edges [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  // Local copy of the block's state. The line stores start unwritten. Entries that
  // were never written are only read while the first row of a frame arrives, and
  // no result depends on them.
  logic [23:0] upper_row [sem_pkg::MaxWidth];
  logic [23:0] lower_row [sem_pkg::MaxWidth];
  logic [23:0] win [9];
  int unsigned col_pos = 0;
  logic [1:0]  row_phase = sem_pkg::PhaseFirst;
  logic [10:0] width_reg = 11'd1024;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // This is the exact rounded square root, saturated at 255.
  function automatic logic [7:0] grad_magnitude(input int gx, input int gy);
    int unsigned s, q;
    s = gx * gx + gy * gy;
    q = 0;
    if (s > 65280) return 8'd255;
    for (int b = 128; b != 0; b >>= 1)
      if ((q + b) * (q + b) <= s) q += b;
    if (s > q * q + q) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic edge_result_t sobel_at(input logic [23:0] w [9], input logic eor,
                                            input logic eof);
    edge_result_t r;
    int p [9];
    int gx, gy;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 9; i++) p[i] = (w[i] >> (16 - 8 * k)) & 8'hFF;
      gx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
      gy = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
      r.mag[k] = grad_magnitude(gx, gy);
    end
    r.eor = eor;
    r.eof = eof;
    return r;
  endfunction

  function automatic int unsigned active_width(input logic [10:0] reg_value);
    if (reg_value == 0) return 1;
    if (reg_value > sem_pkg::MaxWidth) return sem_pkg::MaxWidth;
    return reg_value;
  endfunction

  // Advance the local window by one accepted item and queue the edge results it causes.
  task automatic track_pixel(input pixel_item_t it);
    logic [23:0] pix, above, beside;
    logic [23:0] tail [9];
    int unsigned c, w;
    logic last, emitting, flush;
    flush = (it.kind == ReqFlush);
    pix = flush ? 24'd0 : it.rgb;
    w = active_width(width_reg);
    c = (col_pos >= sem_pkg::MaxWidth) ? 0 : col_pos;
    last = (c >= w - 1);
    emitting = (row_phase != sem_pkg::PhaseFirst);
    above = (row_phase == sem_pkg::PhaseSecond) ? 24'd0 : upper_row[c];
    beside = lower_row[c];
    for (int r = 0; r < 3; r++) begin
      win[r*3] = (c == 0) ? 24'd0 : win[r*3+1];
      win[r*3+1] = (c == 0) ? 24'd0 : win[r*3+2];
    end
    win[2] = above;
    win[5] = beside;
    win[8] = pix;
    upper_row[c] = lower_row[c];
    lower_row[c] = pix;
    if (emitting && c >= 1) expected_edges.push_back(sobel_at(win, 1'b0, 1'b0));
    if (emitting && last) begin
      // The last pixel of the row sees zeros to its right.
      for (int r = 0; r < 3; r++) begin
        tail[r*3] = win[r*3+1];
        tail[r*3+1] = win[r*3+2];
        tail[r*3+2] = 24'd0;
      end
      expected_edges.push_back(sobel_at(tail, 1'b1, flush));
    end
    if (last) begin
      col_pos = 0;
      if (flush) row_phase = sem_pkg::PhaseFirst;
      else if (row_phase == sem_pkg::PhaseFirst) row_phase = sem_pkg::PhaseSecond;
      else row_phase = sem_pkg::PhaseLater;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // The driver. The payload stays unchanged while an offered item waits for in_ready.
  pixel_item_t offered;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_pixel(offered);
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_pixels.pop_front();
          in_valid <= 1'b1;
          req_type <= offered.kind;
          {pixel_red, pixel_green, pixel_blue} <= offered.rgb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver and checker. A hold request keeps out_ready low for a long stretch,
  // so that the block fills up and stalls its input.
  int hold_left = 0;
  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          want = expected_edges.pop_front();
          if (edge_red !== want.mag[0]) report_mismatch("edge_red", edge_red, want.mag[0]);
          if (edge_green !== want.mag[1])
            report_mismatch("edge_green", edge_green, want.mag[1]);
          if (edge_blue !== want.mag[2]) report_mismatch("edge_blue", edge_blue, want.mag[2]);
          if (end_of_row !== want.eor) report_mismatch("end_of_row", end_of_row, want.eor);
          if (end_of_frame !== want.eof)
            report_mismatch("end_of_frame", end_of_frame, want.eof);
        end
      end
      if (hold_request != 0 && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // The watchdog. It counts the cycles in which neither channel moves an item.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // This is a register write. It has a setup phase and then an access phase.
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == sem_pkg::AddrImageWidth) width_reg = value[10:0];
  endtask

  // This reads a register back. The data is sampled in the middle of the access cycle.
  task automatic check_reg(input logic [1:0] addr, input logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[10:0] !== want[10:0]) report_mismatch("image_width readback", prdata, want);
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // The sender pauses here until every expected result has come. Extra cycles then
  // let the block finish any row-end work that is still under way.
  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_edges.size() > 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [23:0] random_rgb();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {$urandom_range(1) ? 8'hFF : 8'h00, 8'h00, $urandom_range(1) ? 8'hFF : 8'h00};
      default: return $urandom;
    endcase
  endfunction

  // Queue one frame. It has a number of pixel rows and then one flush row. Stray
  // flush items may sit inside pixel rows. Stray pixels may sit inside the flush row.
  // In every row, only the last item decides the kind of the row.
  task automatic queue_frame(input int rows, input int unsigned w, input bit mixed);
    pixel_item_t it;
    for (int r = 0; r <= rows; r++)
      for (int unsigned c = 0; c < w; c++) begin
        it.rgb = random_rgb();
        if (r == rows)
          it.kind = (c == w - 1 || !mixed || $urandom_range(3) != 0) ? ReqFlush : ReqPixel;
        else
          it.kind = (c != w - 1 && mixed && $urandom_range(15) == 0) ? ReqFlush : ReqPixel;
        pending_pixels.push_back(it);
      end
  endtask

  task automatic queue_directed(input logic [23:0] rgb, input req_t kind);
    pixel_item_t it;
    it.rgb = rgb;
    it.kind = kind;
    pending_pixels.push_back(it);
  endtask

  initial begin
    int unsigned w;
    int queued;
    int rows;
    bit held;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_reg(sem_pkg::AddrImageWidth, 32'd1024);

    // Directed part, at width 4. It has a hard vertical and horizontal edge on every
    // channel, so that the saturated magnitudes are reached. It then has a flush row
    // with no image rows, which must give nothing. Last comes a frame of a single row.
    send_idle_pct = 26;
    recv_idle_pct = 88;
    write_reg(sem_pkg::AddrImageWidth, 32'd4);
    check_reg(sem_pkg::AddrImageWidth, 32'd4);
    @(negedge clk);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        queue_directed((c < 2) ? 24'h000000 : 24'hFFFFFF, ReqPixel);
    queue_directed(24'hFFFFFF, ReqFlush);
    queue_directed(24'h123456, ReqPixel);
    queue_directed(24'h000000, ReqFlush);
    queue_directed(24'hFFFFFF, ReqFlush);
    for (int c = 0; c < 4; c++) queue_directed(24'hA5A5A5, ReqFlush);
    for (int c = 0; c < 4; c++) queue_directed(24'hFF00FF, ReqPixel);
    for (int c = 0; c < 4; c++) queue_directed(24'h00FF00, ReqFlush);
    wait_idle();

    // A width of 1 is a column of single pixels. A width of 0 acts as 1.
    write_reg(sem_pkg::AddrImageWidth, 32'd1);
    @(negedge clk);
    queue_frame(4, 1, 1'b0);
    wait_idle();
    write_reg(sem_pkg::AddrImageWidth, 32'd0);
    check_reg(sem_pkg::AddrImageWidth, 32'd0);
    @(negedge clk);
    queue_frame(3, 1, 1'b0);
    wait_idle();

    // The random part uses small frames. The width changes only between frames. The
    // idle pattern moves on after each third of the random part.
    queued = 0;
    held = 1'b0;
    while (queued < 510) begin
      if (queued > 340) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (queued > 170) begin
        send_idle_pct = 88;
        recv_idle_pct = 26;
      end
      write_reg(sem_pkg::AddrImageWidth, $urandom_range(12, 2));
      @(negedge clk);
      w = active_width(width_reg);
      if ($urandom_range(9) == 0) begin
        queue_frame(0, w, 1'b1);
        queued += w;
      end else begin
        rows = $urandom_range(5, 1);
        if (queued > 250 && !held) begin
          hold_request = 1;
          held = 1'b1;
          rows = 5;
        end
        queue_frame(rows, w, $urandom_range(1));
        queued += w * (rows + 1);
      end
      wait_idle();
    end

    // A register value above the limit reads back as written.
    write_reg(sem_pkg::AddrImageWidth, 32'd2047);
    check_reg(sem_pkg::AddrImageWidth, 32'd2047);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
